>>> rtl/tksl_pkg.sv
// ----------------------------------------------------------------------------
// tksl_pkg
// Shared types and constants for the top-k smallest sorted list block.
// ----------------------------------------------------------------------------
package tksl_pkg;

  localparam int unsigned MAX_K     = 16;
  localparam int unsigned KEY_WIDTH = 32;

  localparam int unsigned COUNT_W = $clog2(MAX_K + 1);
  localparam int unsigned IDX_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  localparam int unsigned CFG_W      = 7;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned POS_W      = 6;

  localparam logic [PADDR_W-1:0] REG_NUM_KEPT = 3'd0;
  localparam logic [CFG_W-1:0]   NUM_KEPT_RST = 7'd16;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef struct packed {
    logic en;
    logic tail;
  } cell_ctrl_t;

endpackage

>>> rtl/tksl_cell.sv
// ----------------------------------------------------------------------------
// tksl_cell
// One list slot: compares the incoming key with its own entry and keeps,
// loads the new key, or takes the entry of its left neighbor.
// ----------------------------------------------------------------------------
module tksl_cell (
  input  logic              clk_i,
  input  tksl_pkg::cell_ctrl_t ctrl_i,
  input  tksl_pkg::key_t    new_key_i,
  input  logic              new_null_i,
  input  tksl_pkg::key_t    prev_key_i,
  input  logic              prev_null_i,
  input  logic              prev_ge_i,
  output tksl_pkg::key_t    key_o,
  output logic              null_o,
  output logic              lt_o,
  output logic              ge_o
);
  import tksl_pkg::*;

  key_t key_q;
  key_t key_d;
  logic null_q;
  logic null_d;

  assign lt_o = !new_null_i && (null_q || ($signed(new_key_i) < $signed(key_q)));
  assign ge_o = lt_o || ctrl_i.tail;

  always_comb begin
    key_d  = key_q;
    null_d = null_q;
    if (ctrl_i.en && ge_o) begin
      if (prev_ge_i) begin
        key_d  = prev_key_i;
        null_d = prev_null_i;
      end else begin
        key_d  = new_key_i;
        null_d = new_null_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    null_q <= null_d;
  end

  assign key_o  = key_q;
  assign null_o = null_q;

endmodule

>>> rtl/top_k_smallest_sorted_list_core.sv
// ----------------------------------------------------------------------------
// top_k_smallest_sorted_list_core
// Keeps the smallest keys seen since the last clear in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries a key in s_axis_tdata_i and a mode
// and null flag in s_axis_tuser_i. An insert or clear does not block the
// input, and the cell chain compares and shifts all entries in parallel,
// so inserts run at one per cycle while no readout is in progress. A
// readout blocks the input and emits one output transaction per cycle
// while the receiver is ready, one per entry in ascending order with tlast
// on the final one, or a single transaction flagged empty when the list
// holds nothing. An accepted readout moves the sequencer to ST_READ, which
// loads each result into the output register, where it waits until
// m_axis_tready_i is high. The user must write num_kept over the APB port
// only while the block is idle; the block itself does not enforce this.
// Reset empties the list and sets num_kept to 16.
module top_k_smallest_sorted_list_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel_i,
  input  logic                                 penable_i,
  input  logic                                 pwrite_i,
  input  logic [tksl_pkg::PADDR_W-1:0]         paddr_i,
  input  logic [tksl_pkg::PDATA_W-1:0]         pwdata_i,
  output logic [tksl_pkg::PDATA_W-1:0]         prdata_o,
  output logic                                 pready_o,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // key
  input  logic [tksl_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // mode [1:0], key_is_null [2]
  input  logic [tksl_pkg::IN_USER_W-1:0]       s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // out_key [31:0], out_position [37:32], zero fill [39:38]
  output logic [tksl_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // out_is_null [0], list_empty [1]
  output logic [tksl_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);
  import tksl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e     state_q;
  logic [CFG_W-1:0] num_kept_q;
  count_t     count_q;
  count_t     count_d;
  idx_t       idx_q;
  logic       out_valid_q;
  key_t       out_key_q;
  logic [POS_W-1:0] out_pos_q;
  logic       out_null_q;
  logic       out_empty_q;
  logic       out_last_q;

  key_t       cell_key [MAX_K];
  logic       cell_null [MAX_K];
  logic       cell_lt [MAX_K];
  logic       cell_ge [MAX_K];
  cell_ctrl_t cell_ctrl [MAX_K];

  logic       in_fire;
  mode_e      in_mode;
  key_t       in_key;
  logic       in_null;
  count_t     cap;
  logic       has_room;
  count_t     last_cnt;
  logic       lt_last;
  logic       do_insert;
  count_t     fill;
  count_t     tail_cnt;
  logic       cfg_write;
  logic       out_free;
  logic       rd_last;

  // Configuration port
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o  = (paddr_i == REG_NUM_KEPT) ? PDATA_W'(num_kept_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_kept_q <= NUM_KEPT_RST;
    end else if (cfg_write && (paddr_i == REG_NUM_KEPT)) begin
      num_kept_q <= pwdata_i[CFG_W-1:0];
    end
  end

  // Input decode
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode = mode_e'(s_axis_tuser_i[1:0]);
  assign in_null = s_axis_tuser_i[2];
  assign in_key  = in_null ? '0 : KEY_WIDTH'(s_axis_tdata_i);

  always_comb begin
    if (num_kept_q == '0) begin
      cap = count_t'(1);
    end else if (num_kept_q > CFG_W'(MAX_K)) begin
      cap = count_t'(MAX_K);
    end else begin
      cap = num_kept_q[COUNT_W-1:0];
    end
  end

  assign has_room  = (count_q < cap);
  assign last_cnt  = count_q - count_t'(1);
  assign lt_last   = cell_lt[last_cnt[IDX_W-1:0]];
  assign do_insert = in_fire && (in_mode == MODE_INSERT) && (has_room || lt_last);
  assign fill      = has_room ? count_q + count_t'(1) : count_q;
  assign tail_cnt  = fill - count_t'(1);

  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      case (in_mode)
        MODE_INSERT: if (do_insert && has_room) count_d = fill;
        MODE_CLEAR:  count_d = '0;
        default:     count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Cell chain
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign cell_ctrl[i].en   = do_insert && (count_t'(i) < fill);
    assign cell_ctrl[i].tail = (count_t'(i) == tail_cnt);

    if (i == 0) begin : g_head
      tksl_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .new_key_i   (in_key),
        .new_null_i  (in_null),
        .prev_key_i  (in_key),
        .prev_null_i (in_null),
        .prev_ge_i   (1'b0),
        .key_o       (cell_key[i]),
        .null_o      (cell_null[i]),
        .lt_o        (cell_lt[i]),
        .ge_o        (cell_ge[i])
      );
    end else begin : g_body
      tksl_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .new_key_i   (in_key),
        .new_null_i  (in_null),
        .prev_key_i  (cell_key[i-1]),
        .prev_null_i (cell_null[i-1]),
        .prev_ge_i   (cell_ge[i-1]),
        .key_o       (cell_key[i]),
        .null_o      (cell_null[i]),
        .lt_o        (cell_lt[i]),
        .ge_o        (cell_ge[i])
      );
    end
  end

  // Readout sequencer and output register
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign rd_last  = ((count_t'(idx_q) + count_t'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_key_q   <= '0;
      out_pos_q   <= '0;
      out_null_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && m_axis_tready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_fire && (in_mode == MODE_READ)) begin
            state_q <= ST_READ;
            idx_q   <= '0;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (count_q == '0) begin
              out_key_q   <= '0;
              out_pos_q   <= '0;
              out_null_q  <= 1'b0;
              out_empty_q <= 1'b1;
              out_last_q  <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              out_key_q   <= cell_null[idx_q] ? '0 : cell_key[idx_q];
              out_pos_q   <= POS_W'(idx_q);
              out_null_q  <= cell_null[idx_q];
              out_empty_q <= 1'b0;
              out_last_q  <= rd_last;
              if (rd_last) begin
                state_q <= ST_IDLE;
              end else begin
                idx_q <= idx_q + idx_t'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_pos_q, 32'(out_key_q)};
  assign m_axis_tuser_o  = {out_empty_q, out_null_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(MAX_K))
    else $error("entry count exceeds list depth");

  a_read_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !s_axis_tready_o)
    else $error("input accepted during readout");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (!out_last_q && !out_null_q && out_pos_q == '0))
    else $error("empty readout result carries nonzero fields");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + count_t'(1)
         || count_q == '0))
    else $error("entry count changed by more than one");
`endif

endmodule

>>> dv/top_k_smallest_sorted_list_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_smallest_sorted_list_core_tb
// Self-checking bench for the top-k smallest sorted list core.
// A tracker class keeps its own copy of the kept list and the num_kept
// setting, expands every accepted stream transaction into the readout
// entries it must produce, and checks each output transaction against the
// oldest pending entry. Stimulus is a directed opening followed by random
// clear, insert and readout sequences under changing settings and stalls.
// ----------------------------------------------------------------------------
module top_k_smallest_sorted_list_core_tb;
  import tksl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 40;

  typedef struct packed {
    key_t             key;
    logic             is_null;
    logic [POS_W-1:0] position;
    logic             empty;
    logic             last;
  } readout_entry_t;

  class topk_list_tracker;
    key_t           kept_keys[MAX_K];
    logic           kept_nulls[MAX_K];
    int unsigned    kept_count;
    logic [CFG_W-1:0] num_kept;
    readout_entry_t expected_entries[$];
    int unsigned    mismatches;

    function new();
      kept_count = 0;
      num_kept = NUM_KEPT_RST;
      mismatches = 0;
    endfunction

    function void set_num_kept(logic [CFG_W-1:0] value);
      num_kept = value;
    endfunction

    function int unsigned pending();
      return expected_entries.size();
    endfunction

    function bit sorts_before(key_t ka, logic na, key_t kb, logic nb);
      if (na) return 1'b0;
      if (nb) return 1'b1;
      return $signed(ka) < $signed(kb);
    endfunction

    function int unsigned capacity();
      if (num_kept == 0) return 1;
      if (num_kept > MAX_K) return MAX_K;
      return 32'(num_kept);
    endfunction

    function void place_key(key_t key, logic is_null);
      int unsigned n;
      int unsigned slot;
      if (is_null) key = '0;
      if (kept_count < capacity()) begin
        kept_count++;
      end else if (kept_count == 0 ||
                   !sorts_before(key, is_null, kept_keys[kept_count-1],
                                 kept_nulls[kept_count-1])) begin
        return;
      end
      n = kept_count;
      slot = n - 1;
      for (int unsigned i = 0; i + 1 < n; i++) begin
        if (sorts_before(key, is_null, kept_keys[i], kept_nulls[i])) begin
          slot = i;
          break;
        end
      end
      for (int unsigned i = n - 1; i > slot; i--) begin
        kept_keys[i] = kept_keys[i-1];
        kept_nulls[i] = kept_nulls[i-1];
      end
      kept_keys[slot] = key;
      kept_nulls[slot] = is_null;
    endfunction

    function void note_accepted_item(logic [1:0] mode, key_t key, logic is_null);
      readout_entry_t e;
      case (mode)
        MODE_INSERT: place_key(key, is_null);
        MODE_CLEAR:  kept_count = 0;
        MODE_READ: begin
          if (kept_count == 0) begin
            e = '0;
            e.empty = 1'b1;
            expected_entries.push_back(e);
          end else begin
            for (int unsigned i = 0; i < kept_count; i++) begin
              e = '0;
              e.key = kept_nulls[i] ? '0 : kept_keys[i];
              e.is_null = kept_nulls[i];
              e.position = POS_W'(i);
              e.last = (i + 1 == kept_count);
              expected_entries.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_readout_entry(logic [OUT_DATA_W-1:0] data,
                                      logic [OUT_USER_W-1:0] user, logic last);
      readout_entry_t got;
      readout_entry_t want;
      got.key = data[KEY_WIDTH-1:0];
      got.position = data[KEY_WIDTH+POS_W-1:KEY_WIDTH];
      got.is_null = user[0];
      got.empty = user[1];
      got.last = last;
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output key=%h null=%b pos=%0d empty=%b last=%b",
                   $time, got.key, got.is_null, got.position, got.empty, got.last);
        return;
      end
      want = expected_entries.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp key=%h null=%b pos=%0d empty=%b last=%b, ",
                    "got key=%h null=%b pos=%0d empty=%b last=%b"},
                   $time, want.key, want.is_null, want.position, want.empty,
                   want.last, got.key, got.is_null, got.position, got.empty,
                   got.last);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel_i = 1'b0;
  logic                  penable_i = 1'b0;
  logic                  pwrite_i = 1'b0;
  logic [PADDR_W-1:0]    paddr_i = '0;
  logic [PDATA_W-1:0]    pwdata_i = '0;
  logic [PDATA_W-1:0]    prdata_o;
  logic                  pready_o;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  topk_list_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  top_k_smallest_sorted_list_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_readout_entry(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(logic [1:0] mode, key_t key, logic is_null);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= key;
    s_axis_tuser_i <= {is_null, mode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_accepted_item(mode, key, is_null);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_num_kept(logic [PDATA_W-1:0] value);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= REG_NUM_KEPT;
    pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    tracker.set_num_kept(value[CFG_W-1:0]);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(5))
      0: return key_t'($urandom_range(6)) - key_t'(3);
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return key_t'($urandom());
    endcase
  endfunction

  task automatic send_random_insert();
    send_item(MODE_INSERT, pick_key(), $urandom_range(6) == 0);
  endtask

  task automatic run_random_sequences(int unsigned count);
    int unsigned goal;
    int unsigned len;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(4) != 0) send_item(MODE_CLEAR, $urandom(), 1'($urandom_range(1)));
        len = $urandom_range(24);
        repeat (len) send_random_insert();
        if ($urandom_range(9) == 0) wait_drained();
        send_item(MODE_READ, $urandom(), 1'($urandom_range(1)));
      end else begin
        case ($urandom_range(3))
          0: send_item(MODE_UNUSED, $urandom(), 1'($urandom_range(1)));
          1: send_item(MODE_READ, $urandom(), 1'($urandom_range(1)));
          2: send_item(MODE_CLEAR, $urandom(), 1'($urandom_range(1)));
          default: send_item(MODE_INSERT, $urandom(), 1'b1);
        endcase
      end
    end
  endtask

  function automatic logic [PDATA_W-1:0] kept_setting(int unsigned idx);
    case (idx)
      0: return 32'd1;
      1: return 32'd127;
      2: return 32'd4;
      3: return 32'd0;
      4: return 32'd64;
      5: return 32'hFFFF_FF85;
      6: return 32'd16;
      7: return 32'd17;
      default: return 32'd2;
    endcase
  endfunction

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 75;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(MODE_READ, '0, 1'b0);
    send_item(MODE_INSERT, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_INSERT, 32'h8000_0000, 1'b0);
    send_item(MODE_INSERT, 32'h0000_0000, 1'b0);
    send_item(MODE_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_item(MODE_INSERT, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_INSERT, 32'd5, 1'b0);
    send_item(MODE_INSERT, 32'd5, 1'b0);
    send_item(MODE_INSERT, 32'd0, 1'b1);
    send_item(MODE_READ, '0, 1'b0);
    send_item(MODE_UNUSED, 32'hDEAD_BEEF, 1'b1);
    send_item(MODE_READ, '1, 1'b1);
    send_item(MODE_CLEAR, '1, 1'b1);
    send_item(MODE_READ, '0, 1'b0);

    wait_drained();
    write_num_kept(32'd3);
    send_item(MODE_INSERT, 32'd10, 1'b0);
    send_item(MODE_INSERT, 32'd0, 1'b1);
    send_item(MODE_INSERT, 32'd20, 1'b0);
    send_item(MODE_INSERT, 32'd15, 1'b0);
    send_item(MODE_INSERT, 32'd20, 1'b0);
    send_item(MODE_INSERT, 32'd7, 1'b1);
    send_item(MODE_INSERT, 32'd10, 1'b0);
    send_item(MODE_READ, '0, 1'b0);

    wait_drained();
    write_num_kept(32'd1);
    send_item(MODE_INSERT, 32'd12, 1'b0);
    send_item(MODE_READ, '0, 1'b0);

    for (int unsigned p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();
      write_num_kept(kept_setting(p));
      run_random_sequences(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
